[design/prtc_pkg.sv]
// Package for the point rotation block: CORDIC word type, gain, arctangent
// table and the Q1.30 clamp. Used by every module of the block.
// No dependencies.
package prtc_pkg;

    // Width of the CORDIC x, y and z words (Q1.30 plus guard and sign bits)
    localparam int RW           = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W        = 32;

    localparam logic signed [RW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [RW-1:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [RW-1:0] HALF_Q30    = 33'sd536870912;
    localparam logic signed [RW-1:0] PI_B32      = 33'sd2147483648;

    // atan(2^-i) in 32-bit binary angle units
    localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41721,
        30'd20860,     30'd10430,     30'd5215,      30'd2607,     30'd1303,
        30'd651,       30'd325,       30'd162,       30'd81,       30'd40,
        30'd20,        30'd10,        30'd5,         30'd2,        30'd1
    };

    // One CORDIC word as it moves from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } t_cordic;

    // Clamp a CORDIC output to [-1.0, 1.0] in Q1.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] c;
        begin
            if (v > ONE_Q30) begin
                c = ONE_Q30;
            end else if (v < -ONE_Q30) begin
                c = -ONE_Q30;
            end else begin
                c = v;
            end
            clamp_q30 = c[31:0];
        end
    endfunction

endpackage

[design/point_rotate_about_turn_center_top.sv]
// Top level of the point rotation block: input stage, chain of CORDIC cells
// and output stages. Depends on prtc_pkg, prtc_pre, prtc_cell, prtc_post.
//
//  channel   direction  handshake            ports
//  --------  ---------  -------------------  ---------------------------------
//  input     in         start, busy          i_x_in, i_y_in, i_angle, i_radius
//  result    out        o_valid (one cycle)  o_x_out, o_y_out
//
// One word is taken every cycle; busy stays low. Each result passes through
// one input stage, 30 CORDIC cells, then four stages for clamp, multiply,
// round and saturate. The 30-cell chain makes up most of the latency.
// Synchronous reset clears every valid bit; words in flight are dropped.
// The receiver cannot stall, so nothing in the block ever holds.
module point_rotate_about_turn_center_top #(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_x_in,
    input  logic signed [COORD_WIDTH-1:0] i_y_in,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    input  logic signed [COORD_WIDTH-1:0] i_radius,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH-1:0] o_x_out,
    output logic signed [COORD_WIDTH-1:0] o_y_out
);
    import prtc_pkg::*;

    localparam int PW = 3 * COORD_WIDTH + 1;

    t_cordic       rot [CORDIC_STEPS+1];
    logic [PW-1:0] pay [CORDIC_STEPS+1];

    // Fully pipelined: never refuse a word
    assign busy = 1'b0;

    prtc_pre #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH),
        .PW (PW)
    ) u_pre (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start),
        .i_x_in   (i_x_in),
        .i_y_in   (i_y_in),
        .i_angle  (i_angle),
        .i_radius (i_radius),
        .o_rot    (rot[0]),
        .o_pay    (pay[0])
    );

    // Chain of rotation cells
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        prtc_cell #(
            .STEP (g),
            .PW   (PW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rot   (rot[g]),
            .i_pay   (pay[g]),
            .o_rot   (rot[g+1]),
            .o_pay   (pay[g+1])
        );
    end

    prtc_post #(
        .CW (COORD_WIDTH),
        .PW (PW)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rot   (rot[CORDIC_STEPS]),
        .i_pay   (pay[CORDIC_STEPS]),
        .o_valid (o_valid),
        .o_x_out (o_x_out),
        .o_y_out (o_y_out)
    );

endmodule

[design/prtc_pre.sv]
// Input stage of the point rotation block: folds the angle into +-pi/2,
// seeds the CORDIC word and packs the point data. Depends on prtc_pkg.
module prtc_pre #(
    parameter int CW = 24,
    parameter int AW = 16,
    parameter int PW = 73
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [CW-1:0]     i_x_in,
    input  logic signed [CW-1:0]     i_y_in,
    input  logic signed [AW-1:0]     i_angle,
    input  logic signed [CW-1:0]     i_radius,
    output prtc_pkg::t_cordic        o_rot,
    output logic [PW-1:0]            o_pay
);
    import prtc_pkg::*;

    t_cordic              r_rot, n_rot;
    logic [PW-1:0]        r_pay, n_pay;
    logic signed [RW-1:0] ang;
    logic signed [CW:0]   y_off;

    // Extend the angle to 32-bit binary angle and fold it by pi
    always_comb begin
        ang         = RW'($signed({i_angle, {(ANG_W-AW){1'b0}}}));
        n_rot.valid = i_valid;
        n_rot.x     = CORDIC_GAIN;
        n_rot.y     = '0;
        if (ang > ONE_Q30) begin
            n_rot.z    = ang - PI_B32;
            n_rot.flip = 1'b1;
        end else if (ang < -ONE_Q30) begin
            n_rot.z    = ang + PI_B32;
            n_rot.flip = 1'b1;
        end else begin
            n_rot.z    = ang;
            n_rot.flip = 1'b0;
        end
        y_off = (CW+1)'(i_y_in) - (CW+1)'(i_radius);
        n_pay = {i_x_in, y_off, i_radius};
    end

    // Register the seeded word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else begin
            r_rot <= n_rot;
            r_pay <= n_pay;
        end
    end

    assign o_rot = r_rot;
    assign o_pay = r_pay;

endmodule

[design/prtc_cell.sv]
// One CORDIC rotation cell: a single micro-rotation by atan(2^-STEP),
// registered, with the point data riding alongside. Depends on prtc_pkg.
module prtc_cell #(
    parameter int STEP = 0,
    parameter int PW   = 73
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prtc_pkg::t_cordic i_rot,
    input  logic [PW-1:0]     i_pay,
    output prtc_pkg::t_cordic o_rot,
    output logic [PW-1:0]     o_pay
);
    import prtc_pkg::*;

    t_cordic              r_rot, n_rot;
    logic [PW-1:0]        r_pay;
    logic signed [RW-1:0] xs, ys, at;

    // Rotate toward zero residual angle; shifts floor
    always_comb begin
        xs    = $signed(i_rot.x) >>> STEP;
        ys    = $signed(i_rot.y) >>> STEP;
        at    = $signed({3'b000, ATAN_TAB[STEP]});
        n_rot = i_rot;
        if (!i_rot.z[RW-1]) begin
            n_rot.x = $signed(i_rot.x) - ys;
            n_rot.y = $signed(i_rot.y) + xs;
            n_rot.z = $signed(i_rot.z) - at;
        end else begin
            n_rot.x = $signed(i_rot.x) + ys;
            n_rot.y = $signed(i_rot.y) - xs;
            n_rot.z = $signed(i_rot.z) + at;
        end
    end

    // Advance to the next cell every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.valid <= 1'b0;
        end else begin
            r_rot <= n_rot;
            r_pay <= i_pay;
        end
    end

    assign o_rot = r_rot;
    assign o_pay = r_pay;

endmodule

[design/prtc_post.sv]
// Output stages of the point rotation block: sign fix and clamp of cos/sin,
// the four products, rounding, radius add and saturation. Depends on prtc_pkg.
module prtc_post #(
    parameter int CW = 24,
    parameter int PW = 73
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  prtc_pkg::t_cordic    i_rot,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_x_out,
    output logic signed [CW-1:0] o_y_out
);
    import prtc_pkg::*;

    localparam int SW = CW + 35;   // product sum width
    localparam int TW = SW - 30;   // after the Q30 shift
    localparam int YW = TW + 1;    // after the radius add

    logic signed [CW-1:0]  px, pr;
    logic signed [CW:0]    pd;

    // Stage A: cos and sin
    logic                  r_va;
    logic signed [31:0]    r_c, r_s, n_c, n_s;
    logic signed [CW-1:0]  r_xa, r_ra;
    logic signed [CW:0]    r_da;
    logic signed [RW-1:0]  fx, fy;

    // Stage B: products
    logic                  r_vb;
    logic signed [CW+31:0] r_pxc, r_pxs;
    logic signed [CW+32:0] r_pdc, r_pds;
    logic signed [CW-1:0]  r_rb;

    // Stage C: rounded sums
    logic                  r_vc;
    logic signed [SW-1:0]  r_sx, r_sy, n_sx, n_sy;
    logic signed [CW-1:0]  r_rc;

    // Stage D: output
    logic                  r_vd;
    logic signed [CW-1:0]  r_xo, r_yo, n_xo, n_yo;
    logic signed [TW-1:0]  tx, ty;
    logic signed [YW-1:0]  vx, vy;

    assign {px, pd, pr} = i_pay;

    // Undo the pi fold and clamp to unit range
    always_comb begin
        fx  = i_rot.flip ? -$signed(i_rot.x) : $signed(i_rot.x);
        fy  = i_rot.flip ? -$signed(i_rot.y) : $signed(i_rot.y);
        n_c = clamp_q30(fx);
        n_s = clamp_q30(fy);
    end

    // Sum products exactly, add half for round half up
    always_comb begin
        n_sx = SW'(r_pxc) - SW'(r_pds) + SW'(HALF_Q30);
        n_sy = SW'(r_pxs) + SW'(r_pdc) + SW'(HALF_Q30);
    end

    // Drop the Q30 fraction, add radius to y, saturate
    always_comb begin
        tx = r_sx[SW-1:30];
        ty = r_sy[SW-1:30];
        vx = YW'(tx);
        vy = YW'(ty) + YW'(r_rc);
        if (vx[YW-1:CW-1] == {(YW-CW+1){vx[YW-1]}}) begin
            n_xo = vx[CW-1:0];
        end else begin
            n_xo = {vx[YW-1], {(CW-1){~vx[YW-1]}}};
        end
        if (vy[YW-1:CW-1] == {(YW-CW+1){vy[YW-1]}}) begin
            n_yo = vy[CW-1:0];
        end else begin
            n_yo = {vy[YW-1], {(CW-1){~vy[YW-1]}}};
        end
    end

    // Strobe pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_va <= i_rot.valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // Data pipeline
    always_ff @(posedge i_clk) begin
        r_c   <= n_c;
        r_s   <= n_s;
        r_xa  <= px;
        r_da  <= pd;
        r_ra  <= pr;
        r_pxc <= r_xa * r_c;
        r_pxs <= r_xa * r_s;
        r_pdc <= r_da * r_c;
        r_pds <= r_da * r_s;
        r_rb  <= r_ra;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_rc  <= r_rb;
        r_xo  <= n_xo;
        r_yo  <= n_yo;
    end

    assign o_valid = r_vd;
    assign o_x_out = r_xo;
    assign o_y_out = r_yo;

endmodule
